[hw/rtl/priority_lru_task_scheduler_defines.svh]
// Assertion macros for the scheduler RTL
`ifndef PRIORITY_LRU_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_LRU_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PLTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PLTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/plts_pkg.sv]
package plts_pkg;

    // Fixed field widths
    localparam int TABLE_SIZE = 8;
    localparam int PID_W      = 3;
    localparam int TGT_W      = 4;
    localparam int NS_W       = 3;
    localparam int PRIO_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int STATUS_W   = 3;

    // Process state codes
    localparam logic [NS_W-1:0] PS_CREATED = 3'd0;
    localparam logic [NS_W-1:0] PS_RUNNING = 3'd1;
    localparam logic [NS_W-1:0] PS_READY   = 3'd2;

    // Item modes
    localparam logic MODE_SCHED  = 1'b0;
    localparam logic MODE_CHANGE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE,
        STS_IGNORED,
        STS_BAD_STATE,
        STS_PID_RANGE,
        STS_IDLE_TARGET,
        STS_FROM_READY,
        STS_TARGET_RUNNING
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_COMMIT,
        S_CHANGE
    } sched_state_t;

    typedef struct packed {
        logic              mode;
        logic [TGT_W-1:0]  target_pid;
        logic [NS_W-1:0]   new_state;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    running_pid;
        logic [PRIO_W-1:0]   running_prio;
    } result_t;

    // Request to the shared compare unit
    typedef struct packed {
        logic              force_take;
        logic              cand_ready;
        logic [PRIO_W-1:0] cand_prio;
        logic [PRIO_W-1:0] best_prio;
    } cmp_req_t;

endpackage

[hw/rtl/plts_cmp.sv]
// Candidate-versus-best compare: lower priority value, then older stamp
module plts_cmp #(
    parameter int STAMP_BITS = 32
) (
    input  plts_pkg::cmp_req_t     req,
    input  logic [STAMP_BITS-1:0]  cand_stamp,
    input  logic [STAMP_BITS-1:0]  best_stamp,
    output logic                   better
);

    logic prio_lt;
    logic prio_eq;
    logic stamp_lt;

    assign prio_lt  = req.cand_prio < req.best_prio;
    assign prio_eq  = req.cand_prio == req.best_prio;
    assign stamp_lt = cand_stamp < best_stamp;

    // Entry 0 seeds the search; others must be ready and strictly better
    assign better = req.force_take
                  | (req.cand_ready & (prio_lt | (prio_eq & stamp_lt)));

endmodule

[hw/rtl/plts_ctrl.sv]
`include "priority_lru_task_scheduler_defines.svh"

// Sequencer and process table; one table entry is compared per cycle
module plts_ctrl #(
    parameter int PROCESS_COUNT = 8,
    parameter int STAMP_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  plts_pkg::item_t                     item,
    output logic                                busy,
    output logic                                done,
    output plts_pkg::result_t                   result,
    output logic [plts_pkg::CFG_IDX_W-1:0]      prio_addr,
    input  logic [plts_pkg::PRIO_W-1:0]         prio_data
);

    localparam int IDX_W = $clog2(PROCESS_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PROCESS_COUNT - 1);

    plts_pkg::sched_state_t state_reg, state_next;

    logic [plts_pkg::TGT_W-1:0]  tgt_reg;
    logic [plts_pkg::NS_W-1:0]   ns_reg;
    logic [plts_pkg::NS_W-1:0]   entry_state_reg [PROCESS_COUNT];
    logic [STAMP_BITS-1:0]       entry_stamp_reg [PROCESS_COUNT];
    logic [STAMP_BITS-1:0]       count_reg;
    logic [IDX_W-1:0]            cur_pid_reg;
    logic [IDX_W-1:0]            scan_idx_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [plts_pkg::PRIO_W-1:0] best_prio_reg;
    logic [STAMP_BITS-1:0]       best_stamp_reg;
    logic                        done_reg;
    plts_pkg::result_t           result_reg;

    logic                        item_we;
    logic                        st_we;
    logic [IDX_W-1:0]            st_waddr;
    logic [plts_pkg::NS_W-1:0]   st_wdata;
    logic                        stamp_we;
    logic                        scan_clr;
    logic                        scan_step;
    logic                        best_take;
    logic                        cur_load;
    logic                        emit;
    plts_pkg::status_t           emit_status;
    logic [IDX_W-1:0]            emit_pid;
    logic [plts_pkg::PRIO_W-1:0] emit_prio;

    logic [IDX_W-1:0]            tgt_idx;
    logic                        tgt_valid;
    logic [IDX_W-1:0]            rd_idx;
    logic [plts_pkg::NS_W-1:0]   rd_state;
    logic [STAMP_BITS-1:0]       rd_stamp;
    logic [STAMP_BITS-1:0]       count_plus;
    plts_pkg::cmp_req_t          cmp_req;
    logic                        better;
    logic [PROCESS_COUNT-1:0]    run_vec;

    // Table read port and priority lookup
    assign tgt_idx    = tgt_reg[IDX_W-1:0];
    assign tgt_valid  = tgt_reg < plts_pkg::TGT_W'(PROCESS_COUNT);
    assign rd_idx     = (state_reg == plts_pkg::S_SCAN) ? scan_idx_reg : tgt_idx;
    assign rd_state   = entry_state_reg[rd_idx];
    assign rd_stamp   = entry_stamp_reg[scan_idx_reg];
    assign prio_addr  = plts_pkg::CFG_IDX_W'((state_reg == plts_pkg::S_SCAN) ?
                                             scan_idx_reg : cur_pid_reg);
    assign count_plus = count_reg + STAMP_BITS'(1);

    // Shared compare unit
    assign cmp_req.force_take = (scan_idx_reg == '0);
    assign cmp_req.cand_ready = (rd_state == plts_pkg::PS_READY);
    assign cmp_req.cand_prio  = prio_data;
    assign cmp_req.best_prio  = best_prio_reg;

    plts_cmp #(
        .STAMP_BITS (STAMP_BITS)
    ) u_cmp (
        .req        (cmp_req),
        .cand_stamp (rd_stamp),
        .best_stamp (best_stamp_reg),
        .better     (better)
    );

    // Sequencer: next state and controls
    always_comb
    begin
        state_next  = state_reg;
        item_we     = 1'b0;
        st_we       = 1'b0;
        st_waddr    = cur_pid_reg;
        st_wdata    = ns_reg;
        stamp_we    = 1'b0;
        scan_clr    = 1'b0;
        scan_step   = 1'b0;
        best_take   = 1'b0;
        cur_load    = 1'b0;
        emit        = 1'b0;
        emit_status = plts_pkg::STS_DONE;
        emit_pid    = cur_pid_reg;
        emit_prio   = prio_data;

        unique case (state_reg)
            plts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_we    = 1'b1;
                    state_next = (item.mode == plts_pkg::MODE_CHANGE) ?
                                 plts_pkg::S_CHANGE : plts_pkg::S_UPDATE;
                end
            end

            plts_pkg::S_UPDATE:
            begin
                if (ns_reg == plts_pkg::PS_CREATED || ns_reg == plts_pkg::PS_RUNNING)
                begin
                    emit        = 1'b1;
                    emit_status = plts_pkg::STS_BAD_STATE;
                    state_next  = plts_pkg::S_IDLE;
                end
                else
                begin
                    // Retire the running process; idle always goes back to ready
                    st_we      = 1'b1;
                    st_waddr   = cur_pid_reg;
                    st_wdata   = (cur_pid_reg == '0) ? plts_pkg::PS_READY : ns_reg;
                    stamp_we   = 1'b1;
                    scan_clr   = 1'b1;
                    state_next = plts_pkg::S_SCAN;
                end
            end

            plts_pkg::S_SCAN:
            begin
                best_take = better;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = plts_pkg::S_COMMIT;
                end
                else
                begin
                    scan_step = 1'b1;
                end
            end

            plts_pkg::S_COMMIT:
            begin
                st_we      = 1'b1;
                st_waddr   = best_idx_reg;
                st_wdata   = plts_pkg::PS_RUNNING;
                cur_load   = 1'b1;
                emit       = 1'b1;
                emit_pid   = best_idx_reg;
                emit_prio  = best_prio_reg;
                state_next = plts_pkg::S_IDLE;
            end

            plts_pkg::S_CHANGE:
            begin
                emit       = 1'b1;
                state_next = plts_pkg::S_IDLE;
                priority if (tgt_valid && rd_state == plts_pkg::PS_RUNNING &&
                             ns_reg == plts_pkg::PS_READY)
                begin
                    emit_status = plts_pkg::STS_IGNORED;
                end
                else if (ns_reg == plts_pkg::PS_CREATED || ns_reg == plts_pkg::PS_RUNNING)
                begin
                    emit_status = plts_pkg::STS_BAD_STATE;
                end
                else if (!tgt_valid)
                begin
                    emit_status = plts_pkg::STS_PID_RANGE;
                end
                else if (tgt_reg == '0)
                begin
                    emit_status = plts_pkg::STS_IDLE_TARGET;
                end
                else if (rd_state == plts_pkg::PS_READY && ns_reg != plts_pkg::PS_READY)
                begin
                    emit_status = plts_pkg::STS_FROM_READY;
                end
                else if (rd_state == plts_pkg::PS_RUNNING)
                begin
                    emit_status = plts_pkg::STS_TARGET_RUNNING;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_waddr = tgt_idx;
                    st_wdata = ns_reg;
                end
            end

            default:
            begin
                state_next = plts_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latched item
    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            tgt_reg <= item.target_pid;
            ns_reg  <= item.new_state;
        end
    end

    // Process table, switch counter, current process
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PROCESS_COUNT; i++)
            begin
                entry_state_reg[i] <= (i == 0) ? plts_pkg::PS_RUNNING : plts_pkg::PS_READY;
                entry_stamp_reg[i] <= '0;
            end
            count_reg   <= '0;
            cur_pid_reg <= '0;
        end
        else
        begin
            if (st_we)
            begin
                entry_state_reg[st_waddr] <= st_wdata;
            end
            if (stamp_we)
            begin
                entry_stamp_reg[cur_pid_reg] <= count_plus;
                count_reg                    <= count_plus;
            end
            if (cur_load)
            begin
                cur_pid_reg <= best_idx_reg;
            end
        end
    end

    // Scan index and best candidate
    always_ff @(posedge clk)
    begin
        if (scan_clr)
        begin
            scan_idx_reg <= '0;
        end
        else if (scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (best_take)
        begin
            best_idx_reg   <= scan_idx_reg;
            best_prio_reg  <= prio_data;
            best_stamp_reg <= rd_stamp;
        end
    end

    // Result strobe and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.status       <= emit_status;
            result_reg.running_pid  <= plts_pkg::PID_W'(emit_pid);
            result_reg.running_prio <= emit_prio;
        end
    end

    assign busy   = (state_reg != plts_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Running-entry map for checks
    always_comb
    begin
        for (int i = 0; i < PROCESS_COUNT; i++)
        begin
            run_vec[i] = (entry_state_reg[i] == plts_pkg::PS_RUNNING);
        end
    end

    `PLTS_ASSERT_IMP(a_one_running, state_reg == plts_pkg::S_IDLE, $onehot(run_vec) && run_vec[cur_pid_reg], "idle table must hold exactly the current process as running")
    `PLTS_ASSERT_IMP(a_pick_ready, state_reg == plts_pkg::S_COMMIT, entry_state_reg[best_idx_reg] == plts_pkg::PS_READY, "picked process is not ready")
    `PLTS_ASSERT_NXT(a_count_step, stamp_we, count_reg == $past(count_reg) + STAMP_BITS'(1), "switch counter did not advance by one")
    `PLTS_ASSERT_IMP(a_done_source, done_reg, $past(state_reg) != plts_pkg::S_IDLE, "result strobe without an item in work")

endmodule

[hw/rtl/priority_lru_task_scheduler.sv]
// Priority task scheduler. An item is taken when start is high and busy is
// low. A change-state item is decided in S_CHANGE and its result registered
// from there; a schedule item scans the process table one entry per cycle
// through a single compare unit in S_SCAN and registers the pick from
// S_COMMIT, or from S_UPDATE when the return state is refused.
// busy stays high until the result is issued. Every item yields one result,
// shown on result for the single cycle in which done is high; the receiver
// cannot stall it and must take it then. Priority registers are written
// through cfg_we / cfg_index / cfg_data and may only change while busy is low.
module priority_lru_task_scheduler #(
    parameter int PROCESS_COUNT = 8,
    parameter int STAMP_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  plts_pkg::item_t                     item,
    output logic                                busy,
    output logic                                done,
    output plts_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [plts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plts_pkg::PRIO_W-1:0]         cfg_data
);

    logic [plts_pkg::PRIO_W-1:0]    prio_reg [plts_pkg::TABLE_SIZE];
    logic [plts_pkg::CFG_IDX_W-1:0] prio_addr;
    logic [plts_pkg::PRIO_W-1:0]    prio_data;

    // Priority registers: idle process resets to the least urgent level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plts_pkg::TABLE_SIZE; i++)
            begin
                prio_reg[i] <= (i == 0) ? '1 : '0;
            end
        end
        else if (cfg_we)
        begin
            prio_reg[cfg_index] <= cfg_data;
        end
    end

    assign prio_data = prio_reg[prio_addr];

    plts_ctrl #(
        .PROCESS_COUNT (PROCESS_COUNT),
        .STAMP_BITS    (STAMP_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .prio_addr (prio_addr),
        .prio_data (prio_data)
    );

endmodule
